FILE: src/url_percent_encoder_unit_defines.svh
// ---------------------------------------------------------------------------
// url percent encoder assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef URL_PERCENT_ENCODER_UNIT_DEFINES_SVH
`define URL_PERCENT_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define UPE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("upe assertion failed");
`define UPE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("upe reset assertion failed");
`else
`define UPE_ASSERT(lbl, prop)
`define UPE_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: src/upe_pkg.sv
// ---------------------------------------------------------------------------
// url percent encoder package
// transaction types, command record and character helpers
// ---------------------------------------------------------------------------
package upe_pkg;

    localparam int unsigned MaxBytes = 7;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_HEXA  = 8'h57;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_run_end;
        logic       out_string_end;
    } t_out;

    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [2:0]               cnt;
        logic                     last;
    } t_cmd;

    function automatic logic is_alnum(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    function automatic logic is_plain(input logic [7:0] b);
        return is_alnum(b) || (b inside {8'h21, 8'h23, 8'h24, [8'h26:8'h2f],
                                         8'h3a, 8'h3b, 8'h3d, 8'h3f, 8'h40,
                                         8'h5f, 8'h7e});
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v <= 4'd9) ? CH_ZERO + 8'(v) : CH_HEXA + 8'(v);
    endfunction

endpackage

FILE: src/upe_front.sv
// ---------------------------------------------------------------------------
// url percent encoder front
// classifies each input byte against the lookahead hold and builds a command
// ---------------------------------------------------------------------------
module upe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  upe_pkg::t_in  i_in,
    output logic          o_cmd_push,
    output upe_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        HOLD_NONE = 3'b001,
        HOLD_PCT  = 3'b010,
        HOLD_TWO  = 3'b100
    } t_hold;

    t_hold      r_hold, n_hold;
    logic [7:0] r_second, n_second;

    always_comb begin
        logic [7:0]                        b;
        logic                              last;
        logic                              fresh;
        logic                              esc;
        logic                              with_s;
        logic [2:0]                        k;
        logic [upe_pkg::MaxBytes-1:0][7:0] bytes;

        b        = i_in.in_byte;
        last     = i_in.in_last;
        fresh    = 1'b1;
        esc      = 1'b0;
        with_s   = 1'b0;
        k        = 3'd0;
        bytes    = '0;
        n_hold   = HOLD_NONE;
        n_second = 8'h00;

        case (r_hold)
            HOLD_PCT: begin
                if (upe_pkg::is_alnum(b) && !last) begin
                    n_hold   = HOLD_TWO;
                    n_second = b;
                    fresh    = 1'b0;
                end else begin
                    esc = 1'b1;
                end
            end
            HOLD_TWO: begin
                if (upe_pkg::is_alnum(b)) begin
                    bytes[0] = upe_pkg::CH_PCT;
                    bytes[1] = r_second;
                    bytes[2] = b;
                    k        = 3'd3;
                    fresh    = 1'b0;
                end else begin
                    esc    = 1'b1;
                    with_s = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (esc) begin
            bytes[0] = upe_pkg::CH_PCT;
            bytes[1] = upe_pkg::CH_TWO;
            bytes[2] = upe_pkg::CH_FIVE;
            k        = 3'd3;
        end
        if (with_s) begin
            bytes[k] = r_second;
            k        = k + 3'd1;
        end
        if (fresh) begin
            if (upe_pkg::is_plain(b)) begin
                bytes[k] = b;
                k        = k + 3'd1;
            end else if (b == upe_pkg::CH_PCT && !last) begin
                n_hold = HOLD_PCT;
            end else begin
                bytes[k] = upe_pkg::CH_PCT;
                k        = k + 3'd1;
                bytes[k] = upe_pkg::hex_digit(b[7:4]);
                k        = k + 3'd1;
                bytes[k] = upe_pkg::hex_digit(b[3:0]);
                k        = k + 3'd1;
            end
        end

        o_cmd.bytes = bytes;
        o_cmd.cnt   = k;
        o_cmd.last  = last;
        o_cmd_push  = i_accept && (k != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= HOLD_NONE;
            r_second <= 8'h00;
        end else if (i_accept) begin
            r_hold   <= n_hold;
            r_second <= n_second;
        end
    end

endmodule

FILE: src/upe_queue.sv
// ---------------------------------------------------------------------------
// url percent encoder command queue
// two-entry fifo between front and back
// ---------------------------------------------------------------------------
module upe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upe_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output upe_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    upe_pkg::t_cmd r_ent0;
    upe_pkg::t_cmd r_ent1;
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt, n_cnt;

    assign o_cmd   = r_rd ? r_ent1 : r_ent0;
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_comb begin
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (r_wr) begin
                r_ent1 <= i_cmd;
            end else begin
                r_ent0 <= i_cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/upe_back.sv
// ---------------------------------------------------------------------------
// url percent encoder back
// steps through a command one byte per cycle into the output register while it is free or popped
// ---------------------------------------------------------------------------
module upe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upe_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_valid,
    output upe_pkg::t_out o_out
);

    logic [2:0]    r_idx;
    logic          r_ov;
    upe_pkg::t_out r_out, n_out;
    logic          load;
    logic          is_end;

    assign load   = i_cmd_valid && (!r_ov || i_pop);
    assign is_end = (r_idx == i_cmd.cnt - 3'd1);

    always_comb begin
        n_out.out_byte       = i_cmd.bytes[r_idx];
        n_out.out_run_end    = is_end;
        n_out.out_string_end = is_end && i_cmd.last;
    end

    assign o_cmd_pop = load && is_end;
    assign o_valid   = r_ov;
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_ov  <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= is_end ? 3'd0 : r_idx + 3'd1;
                r_ov  <= 1'b1;
            end else if (i_pop) begin
                r_ov  <= 1'b0;
            end
        end
    end

endmodule

FILE: src/url_percent_encoder_unit.sv
// the first result passes the command queue, then the output register, before it is visible
// each result byte occupies the output register in turn, so an input yields
// one byte when it passes plain, three when escaped, up to seven at most
// the back stage drains one byte per cycle while the output is popped and sets sustained throughput
// synchronous active-low reset empties the queue and clears the lookahead hold
// ---------------------------------------------------------------------------
// url percent encoder unit
// percent encodes a byte stream with a two-byte lookahead for escapes
// ---------------------------------------------------------------------------
`include "url_percent_encoder_unit_defines.svh"

module url_percent_encoder_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  upe_pkg::t_in   i_in_data,
    output logic           empty,
    input  logic           pop,
    output upe_pkg::t_out  o_out_data
);

    logic          accept;
    logic          cmd_push;
    upe_pkg::t_cmd front_cmd;
    upe_pkg::t_cmd head_cmd;
    logic          q_full;
    logic          q_empty;
    logic          cmd_pop;
    logic          out_valid;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    upe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in_data),
        .o_cmd_push (cmd_push),
        .o_cmd      (front_cmd)
    );

    upe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .i_pop   (cmd_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    upe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_valid (!q_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop && out_valid),
        .o_valid     (out_valid),
        .o_out       (o_out_data)
    );

    `UPE_ASSERT(a_queue_flags, !(q_full && q_empty))
    `UPE_ASSERT(a_no_push_when_full, cmd_push |-> !q_full)
    `UPE_ASSERT(a_pop_only_when_held, cmd_pop |-> !q_empty)
    `UPE_ASSERT_RST(a_reset_empty, !i_rst_n |=> empty)

endmodule

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// url percent encoder unit testbench
// streams source strings into the encoder, predicts the encoded bytes with a
// local lookahead model and compares every popped transaction in order
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [2:0] {
        HOLD_NONE     = 3'b001,
        HOLD_PCT      = 3'b010,
        HOLD_PCT_BYTE = 3'b100
    } t_hold;

    logic          i_clk     = 1'b0;
    logic          i_rst_n   = 1'b0;
    logic          push      = 1'b0;
    logic          pop       = 1'b0;
    upe_pkg::t_in  i_in_data = '0;
    logic          full;
    logic          empty;
    upe_pkg::t_out o_out_data;

    upe_pkg::t_out encoded_q[$];
    logic [7:0]    run_q[$];
    t_hold         hold_state  = HOLD_NONE;
    logic [7:0]    hold_second = 8'h00;
    string         reserved_chars = "!#$&'()*+,-./:;=?@_~";
    bit            tx_stall = 1'b1;
    bit            rx_stall = 1'b1;
    int            mismatches = 0;
    int            cycles = 0;

    url_percent_encoder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_data  (i_in_data),
        .empty      (empty),
        .pop        (pop),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic alnum_char(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic plain_char(input logic [7:0] b);
        if (alnum_char(b)) begin
            return 1'b1;
        end
        for (int i = 0; i < reserved_chars.len(); i++) begin
            if (reserved_chars[i] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v <= 4'd9) ? 8'h30 + 8'(v) : 8'h61 - 8'd10 + 8'(v);
    endfunction

    function automatic void put_escaped(input logic [7:0] b);
        run_q = {run_q, upe_pkg::CH_PCT};
        run_q = {run_q, hex_char(b[7:4])};
        run_q = {run_q, hex_char(b[3:0])};
    endfunction

    function automatic void take_fresh(input logic [7:0] b, input logic last);
        if (plain_char(b)) begin
            run_q = {run_q, b};
        end else if (b == upe_pkg::CH_PCT && !last) begin
            hold_state  = HOLD_PCT;
            hold_second = 8'h00;
        end else begin
            put_escaped(b);
        end
    endfunction

    function automatic void predict_encoding(input upe_pkg::t_in x);
        t_hold         prev;
        logic [7:0]    sec;
        upe_pkg::t_out r;
        prev        = hold_state;
        sec         = hold_second;
        hold_state  = HOLD_NONE;
        hold_second = 8'h00;
        run_q.delete();
        case (prev)
            HOLD_PCT: begin
                if (alnum_char(x.in_byte) && !x.in_last) begin
                    hold_state  = HOLD_PCT_BYTE;
                    hold_second = x.in_byte;
                end else begin
                    put_escaped(upe_pkg::CH_PCT);
                    take_fresh(x.in_byte, x.in_last);
                end
            end
            HOLD_PCT_BYTE: begin
                if (alnum_char(x.in_byte)) begin
                    run_q = {run_q, upe_pkg::CH_PCT};
                    run_q = {run_q, sec};
                    run_q = {run_q, x.in_byte};
                end else begin
                    put_escaped(upe_pkg::CH_PCT);
                    run_q = {run_q, sec};
                    take_fresh(x.in_byte, x.in_last);
                end
            end
            default: begin
                take_fresh(x.in_byte, x.in_last);
            end
        endcase
        for (int i = 0; i < run_q.size(); i++) begin
            r.out_byte       = run_q[i];
            r.out_run_end    = (i == run_q.size() - 1);
            r.out_string_end = (i == run_q.size() - 1) && x.in_last;
            encoded_q = {encoded_q, r};
        end
    endfunction

    function automatic void report_mismatch(input string kind, input upe_pkg::t_out e,
                                            input upe_pkg::t_out g);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("tb: %s at %0t: expected %h/%b/%b, got %h/%b/%b",
                     kind, $realtime, e.out_byte, e.out_run_end, e.out_string_end,
                     g.out_byte, g.out_run_end, g.out_string_end);
        end
    endfunction

    // scoreboard: check the popped transaction, then predict the pushed one
    always @(posedge i_clk) begin
        upe_pkg::t_out e;
        if (!i_rst_n) begin
            hold_state  = HOLD_NONE;
            hold_second = 8'h00;
        end else begin
            if (pop && !empty) begin
                if (encoded_q.size() == 0) begin
                    report_mismatch("unexpected result", '0, o_out_data);
                end else begin
                    e = encoded_q.pop_front();
                    if (o_out_data.out_byte !== e.out_byte
                            || o_out_data.out_run_end !== e.out_run_end
                            || o_out_data.out_string_end !== e.out_string_end) begin
                        report_mismatch("mismatch", e, o_out_data);
                    end
                end
            end
            if (push && !full) begin
                predict_encoding(i_in_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= rx_stall ? ($urandom_range(0, 99) >= 33) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        while (tx_stall && $urandom_range(0, 99) < 33) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_data <= '{in_byte: b, in_last: last};
        do begin
            @(posedge i_clk);
        end while (full);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (encoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_alnum();
        int k;
        k = $urandom_range(0, 61);
        if (k < 10) begin
            return 8'h30 + 8'(k);
        end else if (k < 36) begin
            return 8'h41 + 8'(k - 10);
        end
        return 8'h61 + 8'(k - 36);
    endfunction

    task automatic send_random_string(input int max_len, inout int n_sent);
        logic [7:0] str_q[$];
        logic [7:0] c;
        int         len;
        int         k;
        len = $urandom_range(1, max_len);
        while (str_q.size() < len) begin
            k = $urandom_range(0, 99);
            if (k < 30) begin
                str_q = {str_q, rand_alnum()};
            end else if (k < 48) begin
                c     = reserved_chars[$urandom_range(0, 19)];
                str_q = {str_q, c};
            end else if (k < 63) begin
                str_q = {str_q, upe_pkg::CH_PCT};
                str_q = {str_q, rand_alnum()};
                str_q = {str_q, rand_alnum()};
            end else if (k < 72) begin
                str_q = {str_q, upe_pkg::CH_PCT};
                if ($urandom_range(0, 1)) begin
                    str_q = {str_q, rand_alnum()};
                end
                c     = $urandom_range(0, 1) ? reserved_chars[$urandom_range(0, 19)]
                                             : 8'($urandom_range(0, 255));
                str_q = {str_q, c};
            end else if (k < 77) begin
                // string cut right after a percent, or after a percent and one alnum
                str_q = {str_q, upe_pkg::CH_PCT};
                if ($urandom_range(0, 1)) begin
                    str_q = {str_q, rand_alnum()};
                end
                break;
            end else begin
                c     = 8'($urandom_range(0, 255));
                str_q = {str_q, c};
            end
        end
        foreach (str_q[i]) begin
            send_item(str_q[i], i == str_q.size() - 1);
        end
        n_sent += str_q.size();
    endtask

    task automatic test_directed();
        logic [7:0] seq_b[$];
        int         seq_l[$];
        seq_b = '{8'h00, 8'hff, 8'h80, "A", "z", "~", " ",
                  "%", "4", "1",
                  "%", "z", " ",
                  "%", "!",
                  "%", "a",
                  "%",
                  "%", "a", "b",
                  "%", "%", "7", "F"};
        seq_l = '{0, 0, 0, 0, 0, 0, 0,
                  0, 0, 0,
                  0, 0, 0,
                  0, 0,
                  0, 1,
                  1,
                  0, 0, 1,
                  0, 0, 0, 1};
        foreach (seq_b[i]) begin
            send_item(seq_b[i], 1'(seq_l[i]));
        end
    endtask

    task automatic test_random_traffic(input int items);
        int n;
        n = 0;
        while (n < items) begin
            send_random_string(12, n);
        end
    endtask

    task automatic test_drain_pause();
        int n;
        n = 0;
        send_item(upe_pkg::CH_PCT, 1'b0);
        send_item("a", 1'b0);
        wait_drained();
        send_item("b", 1'b1);
        send_random_string(10, n);
        wait_drained();
        send_item(upe_pkg::CH_PCT, 1'b0);
        wait_drained();
        send_item("-", 1'b1);
    endtask

    task automatic test_full_rate(input int items);
        tx_stall = 1'b0;
        rx_stall = 1'b0;
        test_random_traffic(items);
        tx_stall = 1'b1;
        rx_stall = 1'b1;
    endtask

    task automatic test_output_stall(input int items);
        tx_stall = 1'b0;
        test_random_traffic(items);
        tx_stall = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic(120);
        test_drain_pause();
        test_full_rate(80);
        test_output_stall(40);
        test_random_traffic(40);
        wait_drained();
        if (mismatches == 0 && encoded_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
